// ===== rtl/core/cle_pkg.sv =====
// Shared constants and types for the CPU load decay estimator.
package cle_pkg;

    localparam int FRACTION_BITS_DEF = 24;
    localparam int GAIN_SCALE_BITS   = 40;

    localparam int THR_W   = 16;
    localparam int GAIN_W  = 25;
    localparam int TIME_W  = 32;
    localparam int PCT_W   = 7;
    localparam int CFG_A_W = 1;

    localparam logic [THR_W-1:0]  THR_RESET  = 16'd64;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 25'd2749;
    localparam int                PCT_SCALE  = 100;

    localparam logic [CFG_A_W-1:0] CFG_IDLE_THRESHOLD = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_RATE_GAIN      = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_WEIGHT,
        S_MUL_STEP,
        S_UPDATE,
        S_MUL_PCT,
        S_OUT
    } t_state;

endpackage

// ===== rtl/core/cpu_load_decay_estimator.sv =====
// CPU load estimator: moving average of busy time from idle-loop timestamps.
//
//  channel   | dir | handshake                   | payload
//  s_axis    | in  | i_s_axis_tvalid/o_..._tready | tuser: op; tdata: now_cycles
//  m_axis    | out | o_m_axis_tvalid/i_..._tready | tdata: usage_percent
//  cfg       | in  | i_cfg_we                     | i_cfg_addr, i_cfg_wdata
//
// The result passes through S_MUL_WEIGHT, S_MUL_STEP, S_UPDATE, S_MUL_PCT and S_OUT after the
// input transfer: one shared multiplier is used three times in sequence (gap * gain, usage * weight, usage * 100).
// Synchronous active-low reset clears state, registers to defaults, output valid.
// The input is taken only while the sequencer is idle, so a new transfer waits until the last one is through; a
// result waiting in the output register does not block the next transfer, only
// the next result.
module cpu_load_decay_estimator #(
    parameter int FRACTION_BITS = cle_pkg::FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [cle_pkg::TIME_W-1:0]   i_s_axis_tdata,  // [31:0] now_cycles
    input  logic                         i_s_axis_tuser,  // [0] op
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [7:0]                   o_m_axis_tdata,  // [6:0] usage_percent
    input  logic                         i_cfg_we,
    input  logic [cle_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [cle_pkg::GAIN_W-1:0]   i_cfg_wdata
);

    localparam int UW = FRACTION_BITS + 1;
    localparam int MA = cle_pkg::TIME_W;
    localparam int MB = (UW > cle_pkg::GAIN_W) ? UW : cle_pkg::GAIN_W;
    localparam int PW = MA + MB;
    localparam int SH = cle_pkg::GAIN_SCALE_BITS - FRACTION_BITS;
    localparam logic [UW-1:0] ONE = UW'(1) << FRACTION_BITS;

    cle_pkg::t_state r_state, n_state;

    logic [cle_pkg::THR_W-1:0]  r_thr;
    logic [cle_pkg::GAIN_W-1:0] r_gain;
    logic [cle_pkg::TIME_W-1:0] r_last;
    logic [UW-1:0]              r_usage;
    logic [cle_pkg::TIME_W-1:0] r_gap;
    logic                       r_step, r_decay, r_tick;
    logic [PW-1:0]              r_prod;
    logic [UW-1:0]              r_res;
    logic                       r_out_valid;
    logic [cle_pkg::PCT_W-1:0]  r_out_pct;

    logic                       s_xfer;
    logic [cle_pkg::TIME_W-1:0] gap_c;
    logic [MA-1:0]              mul_a;
    logic [MB-1:0]              mul_b;
    logic [PW-1:0]              mul_p;
    logic [PW-1:0]              w_full;
    logic [UW-1:0]              w_sat;
    logic [UW-1:0]              u_sel;
    logic [UW-1:0]              delta;
    logic [UW:0]                u_sum;
    logic [UW-1:0]              u_new;
    logic                       prod_en, out_load;

    assign s_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign gap_c  = i_s_axis_tdata - r_last;

    assign w_full = r_prod >> SH;
    assign w_sat  = (w_full > PW'(ONE)) ? ONE : w_full[UW-1:0];
    assign u_sel  = r_decay ? r_usage : (ONE - r_usage);

    assign delta = UW'(r_prod >> FRACTION_BITS);
    assign u_sum = r_decay ? ({1'b0, r_usage} - {1'b0, delta})
                           : ({1'b0, r_usage} + {1'b0, delta});
    always_comb begin
        if (!r_step) begin
            u_new = r_usage;
        end else if (u_sum > {1'b0, ONE}) begin
            u_new = ONE;
        end else begin
            u_new = u_sum[UW-1:0];
        end
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cle_pkg::S_IDLE:       if (s_xfer) n_state = cle_pkg::S_MUL_WEIGHT;
            cle_pkg::S_MUL_WEIGHT: n_state = cle_pkg::S_MUL_STEP;
            cle_pkg::S_MUL_STEP:   n_state = cle_pkg::S_UPDATE;
            cle_pkg::S_UPDATE:     n_state = cle_pkg::S_MUL_PCT;
            cle_pkg::S_MUL_PCT:    n_state = cle_pkg::S_OUT;
            cle_pkg::S_OUT:        if (!r_out_valid || i_m_axis_tready) n_state = cle_pkg::S_IDLE;
            default:               n_state = cle_pkg::S_IDLE;
        endcase
    end

    // outputs: multiplier operands and load enables
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        prod_en  = 1'b0;
        out_load = 1'b0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            cle_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            cle_pkg::S_MUL_WEIGHT: begin
                mul_a   = r_gap;
                mul_b   = MB'(r_gain);
                prod_en = 1'b1;
            end
            cle_pkg::S_MUL_STEP: begin
                mul_a   = MA'(u_sel);
                mul_b   = MB'(w_sat);
                prod_en = 1'b1;
            end
            cle_pkg::S_UPDATE: begin
            end
            cle_pkg::S_MUL_PCT: begin
                mul_a   = MA'(r_res);
                mul_b   = MB'(cle_pkg::PCT_SCALE);
                prod_en = 1'b1;
            end
            cle_pkg::S_OUT: begin
                out_load = !r_out_valid || i_m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::S_IDLE;
            r_thr       <= cle_pkg::THR_RESET;
            r_gain      <= cle_pkg::GAIN_RESET;
            r_last      <= '0;
            r_usage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    cle_pkg::CFG_IDLE_THRESHOLD: r_thr  <= i_cfg_wdata[cle_pkg::THR_W-1:0];
                    cle_pkg::CFG_RATE_GAIN:      r_gain <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_xfer && !i_s_axis_tuser) begin
                r_last <= i_s_axis_tdata;
            end
            if (r_state == cle_pkg::S_UPDATE && r_tick) begin
                r_usage <= u_new;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_gap   <= gap_c;
            r_tick  <= !i_s_axis_tuser;
            r_step  <= !i_s_axis_tuser || (gap_c > MA'(r_thr));
            r_decay <= !i_s_axis_tuser && (gap_c < MA'(r_thr));
        end
        if (prod_en) begin
            r_prod <= mul_p;
        end
        if (r_state == cle_pkg::S_UPDATE) begin
            r_res <= u_new;
        end
        if (out_load) begin
            r_out_pct <= cle_pkg::PCT_W'(r_prod >> FRACTION_BITS);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_pct};

endmodule

// ===== test/cpu_load_decay_estimator_tb.sv =====
// Testbench for the CPU load decay estimator with a built-in load predictor.
`timescale 1ns / 100ps

module cpu_load_decay_estimator_tb;

    localparam int FRAC            = cle_pkg::FRACTION_BITS_DEF;
    localparam int GAIN_SCALE_BITS = cle_pkg::GAIN_SCALE_BITS;
    localparam int THR_W           = cle_pkg::THR_W;
    localparam int GAIN_W          = cle_pkg::GAIN_W;
    localparam int TIME_W          = cle_pkg::TIME_W;
    localparam int PCT_W           = cle_pkg::PCT_W;
    localparam int CFG_A_W         = cle_pkg::CFG_A_W;
    localparam int PCT_SCALE       = cle_pkg::PCT_SCALE;
    localparam logic [THR_W-1:0]  THR_RESET  = cle_pkg::THR_RESET;
    localparam logic [GAIN_W-1:0] GAIN_RESET = cle_pkg::GAIN_RESET;

    localparam logic [63:0] ONE_FRAC = 64'd1 << FRAC;
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_QUERY  = 1'b1;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 600000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic [TIME_W-1:0]   s_data = '0;
    logic                s_user = 1'b0;
    logic                m_ready = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr = cle_pkg::CFG_IDLE_THRESHOLD;
    logic [GAIN_W-1:0]   cfg_wdata = '0;
    logic                s_ready;
    logic                m_valid;
    logic [7:0]          m_data;

    // predictor state
    logic [THR_W-1:0]    thr_reg = THR_RESET;
    logic [GAIN_W-1:0]   gain_reg = GAIN_RESET;
    logic [TIME_W-1:0]   last_tick = '0;
    logic [FRAC:0]       usage_frac = '0;

    logic [PCT_W-1:0]    percent_q[$];
    logic [PCT_W-1:0]    pct_want;
    int                  mismatches = 0;
    int                  cycles = 0;
    int                  stall_cnt = 0;
    bit                  bubbles_on = 1'b1;

    cpu_load_decay_estimator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [31:0] now_cycles
        .i_s_axis_tuser  (s_user),   // [0] op
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [6:0] usage_percent
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] weight_of(input logic [TIME_W-1:0] gap);
        logic [63:0] w;
        w = (64'(gap) * 64'(gain_reg)) >> (GAIN_SCALE_BITS - FRAC);
        return (w > ONE_FRAC) ? ONE_FRAC : w;
    endfunction

    function automatic logic [63:0] raise_load(input logic [63:0] u,
                                               input logic [TIME_W-1:0] gap);
        return u + (((ONE_FRAC - u) * weight_of(gap)) >> FRAC);
    endfunction

    function automatic logic [PCT_W-1:0] next_load_percent(input logic op,
                                                           input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] gap;
        logic [63:0]       u;
        gap = now - last_tick;
        u = 64'(usage_frac);
        if (op == OP_TICK) begin
            last_tick = now;
            if (gap < TIME_W'(thr_reg)) begin
                u = u - ((u * weight_of(gap)) >> FRAC);
            end else begin
                u = raise_load(u, gap);
            end
            if (u > ONE_FRAC) u = ONE_FRAC;
            usage_frac = u[FRAC:0];
        end else begin
            if (gap > TIME_W'(thr_reg)) u = raise_load(u, gap);
            if (u > ONE_FRAC) u = ONE_FRAC;
        end
        return PCT_W'((u * PCT_SCALE) >> FRAC);
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("%s", what);
    endtask

    // result side: random stall bursts, compare each transfer with oldest prediction
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            if (percent_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result: got %0d", m_data));
            end else begin
                pct_want = percent_q.pop_front();
                if (m_data !== {1'b0, pct_want})
                    note_mismatch($sformatf("usage_percent mismatch: expected %0d got %0d",
                                            pct_want, m_data));
            end
        end
        if (stall_cnt > 0) begin
            stall_cnt--;
        end else if (bubbles_on && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(1, 18);
        end
        m_ready <= (stall_cnt == 0);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [TIME_W-1:0] now);
        if (bubbles_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= now;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        percent_q.push_back(next_load_percent(op, now));
    endtask

    task automatic stream_stop();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (percent_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // both registers, written back to back while the block is idle
    task automatic reconfigure(input logic [GAIN_W-1:0] thr, input logic [GAIN_W-1:0] gain);
        stream_stop();
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= cle_pkg::CFG_IDLE_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        thr_reg   = thr[THR_W-1:0];
        cfg_addr  <= cle_pkg::CFG_RATE_GAIN;
        cfg_wdata <= gain;
        @(posedge clk);
        gain_reg  = gain;
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] pick_gap();
        logic [TIME_W-1:0] lim;
        lim = TIME_W'(1) << $urandom_range(0, 31);
        case ($urandom_range(0, 5))
            0: return TIME_W'(thr_reg) + TIME_W'($urandom_range(0, 2)) - 1;
            1: return $urandom_range(0, thr_reg);
            2: return TIME_W'(thr_reg) + $urandom_range(0, 4096);
            3: return $urandom_range(0, lim);
            4: return $urandom;
            default: return $urandom_range(0, 64);
        endcase
    endfunction

    task automatic test_default_ticks();
        send_item(OP_TICK, 32'd0);            // first tick measured from time 0
        send_item(OP_QUERY, 32'd63);
        send_item(OP_TICK, 32'd63);           // idle gap just below threshold
        send_item(OP_QUERY, 32'd127);         // gap equal to threshold: query adds nothing
        send_item(OP_TICK, 32'd127);          // gap equal to threshold: tick rises
        send_item(OP_QUERY, 32'hFFFF_FFFF);   // pending busy time saturates
        send_item(OP_TICK, 32'hFFFF_FFFF);
        send_item(OP_TICK, 32'h0000_0010);    // counter wrap
        send_item(OP_QUERY, 32'h7FFF_FFFF);
    endtask

    task automatic test_register_extremes();
        reconfigure(25'h1FF_FFFF, 25'h1FF_FFFF);   // threshold masked to 16 bits
        send_item(OP_TICK, last_tick + 32'd65534); // idle with saturated weight: drops to 0
        send_item(OP_TICK, last_tick + 32'd65535); // busy with saturated weight: jumps to 1.0
        send_item(OP_QUERY, last_tick + 32'd1);
        send_item(OP_TICK, last_tick + 32'd65534);
        reconfigure(25'd0, 25'd0);                  // zero gain leaves usage alone
        send_item(OP_TICK, last_tick + 32'd5);
        send_item(OP_QUERY, last_tick + 32'd100);
        send_item(OP_TICK, last_tick);
        reconfigure(25'd1, 25'd1);
        send_item(OP_TICK, last_tick);
        send_item(OP_TICK, last_tick + 32'd1);
        reconfigure(25'h000_8000, 25'h100_0000);
        send_item(OP_TICK, last_tick + 32'h8000);
        send_item(OP_QUERY, last_tick + 32'h8001);
        send_item(OP_TICK, last_tick + 32'h4000);
        send_item(OP_QUERY, 32'hAAAA_5555);
    endtask

    task automatic run_load_phase(input int n_items, input logic [GAIN_W-1:0] thr,
                                  input logic [GAIN_W-1:0] gain);
        logic op;
        reconfigure(thr, gain);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                send_item(1'($urandom), $urandom);
            end else begin
                op = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_TICK;
                send_item(op, last_tick + pick_gap());
            end
            if (i == n_items / 2 || $urandom_range(0, 79) == 0) begin
                stream_stop();
                wait_drain();
            end
        end
    endtask

    task automatic test_random_load();
        bubbles_on = 1'b1;
        run_load_phase(200, 25'($urandom_range(0, 65535)),
                       25'($urandom_range(1 << 20, 25'h1FF_FFFF)));
        run_load_phase(200, 25'd0, 25'h1FF_FFFF);
        bubbles_on = 1'b0;
        run_load_phase(200, {9'($urandom), 16'hFFFF}, 25'($urandom_range(1, 1 << 24)));
        bubbles_on = 1'b1;
        run_load_phase(200, 25'($urandom_range(0, 2000)), 25'($urandom));
    endtask

    task automatic test_back_to_back();
        bubbles_on = 1'b0;
        run_load_phase(180, 25'($urandom_range(0, 65535)),
                       25'($urandom_range(1 << 22, 25'h1FF_FFFF)));
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_ticks();
        test_register_extremes();
        test_random_load();
        test_back_to_back();
        stream_stop();
        wait_drain();
        if (mismatches == 0 && percent_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== cpu_load_decay_estimator.f =====
rtl/core/cle_pkg.sv
rtl/core/cpu_load_decay_estimator.sv
test/cpu_load_decay_estimator_tb.sv
